// ===== rtl/fba_pkg.sv =====
package fba_pkg;

  // Map geometry (MAP_WORD_BITS is a power of two, at least eight)
  localparam int FRAME_COUNT   = 1048576;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_DEPTH     = (FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FRAME_W  = 20;
  localparam int COUNT_W  = 16;
  localparam int RUN_W    = COUNT_W + 1;

  // Scan granularity inside a mixed word
  localparam int CHUNK_BITS = 8;
  localparam int CHUNKS     = MAP_WORD_BITS / CHUNK_BITS;
  localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CBIT_W     = $clog2(CHUNK_BITS);

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;
  localparam map_word_t WORD_FULL = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_RESERVE = 2'd1,
    FN_RELEASE = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_REQ  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RESERVE,
    OP_RELEASE,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] first;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    E_CLEAR,
    E_IDLE,
    E_SCAN_RD,
    E_SCAN_EXAM,
    E_SCAN_CHUNK,
    E_MARK_RD,
    E_MARK_WR,
    E_RESP
  } eng_state_t;

endpackage

// ===== rtl/fba_if.sv =====
interface fba_req_if;
  logic                         valid;
  logic                         ready;
  logic [fba_pkg::FUNC_W-1:0]   func;
  logic [fba_pkg::FRAME_W-1:0]  first_frame;
  logic [fba_pkg::COUNT_W-1:0]  count;

  modport source (output valid, func, first_frame, count, input ready);
  modport sink   (input valid, func, first_frame, count, output ready);
endinterface

interface fba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::STATUS_W-1:0]  status;
  logic [fba_pkg::FRAME_W-1:0]   base_frame;

  modport source (output valid, status, base_frame, input ready);
  modport sink   (input valid, status, base_frame, output ready);
endinterface

// ===== rtl/fba_front.sv =====
module fba_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            enable,
  fba_req_if.sink         req,
  output logic            push_valid,
  input  logic            push_ready,
  output fba_pkg::cmd_t   push_cmd
);

  logic                       vld;
  fba_pkg::cmd_t              cmd;
  fba_pkg::cmd_t              cmd_next;
  logic [fba_pkg::FRAME_W:0]  range_end;
  logic                       past_end;

  assign req.ready  = enable && (!vld || push_ready);
  assign push_valid = vld;
  assign push_cmd   = cmd;

  // Classify the incoming transaction
  assign range_end = (fba_pkg::FRAME_W+1)'(req.first_frame)
                   + (fba_pkg::FRAME_W+1)'(req.count);
  assign past_end  = range_end > (fba_pkg::FRAME_W+1)'(fba_pkg::FRAME_COUNT);

  always_comb begin
    cmd_next.first = req.first_frame;
    cmd_next.count = req.count;
    if (req.count == '0) begin
      cmd_next.op = fba_pkg::OP_REJECT;
    end else begin
      case (fba_pkg::func_t'(req.func))
        fba_pkg::FN_ALLOC:   cmd_next.op = fba_pkg::OP_ALLOC;
        fba_pkg::FN_RESERVE: cmd_next.op = past_end ? fba_pkg::OP_REJECT : fba_pkg::OP_RESERVE;
        fba_pkg::FN_RELEASE: cmd_next.op = past_end ? fba_pkg::OP_REJECT : fba_pkg::OP_RELEASE;
        default:             cmd_next.op = fba_pkg::OP_REJECT;
      endcase
    end
  end

  // Hold the classified command until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (req.valid && req.ready) begin
      vld <= 1'b1;
    end else if (push_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== rtl/fba_cmd_fifo.sv =====
module fba_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  fba_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fba_pkg::cmd_t  pop_cmd
);

  fba_pkg::cmd_t  slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_cmd    = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/fba_engine.sv =====
module fba_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  fba_pkg::cmd_t  cmd,
  output logic           clear_done,
  fba_rsp_if.source      rsp
);

  localparam int W = fba_pkg::MAP_WORD_BITS;

  fba_pkg::map_word_t  mem [fba_pkg::MAP_DEPTH];
  fba_pkg::map_word_t  rdata;
  fba_pkg::map_word_t  wbuf;
  fba_pkg::map_word_t  mask;
  fba_pkg::map_word_t  wdata;
  logic                we;

  fba_pkg::eng_state_t  state, state_next;
  logic [fba_pkg::ADDR_W-1:0]   addr;
  logic [fba_pkg::RUN_W-1:0]    run;
  logic [fba_pkg::COUNT_W-1:0]  need_n;
  logic [fba_pkg::CHUNK_W-1:0]  chunk;
  logic [fba_pkg::FRAME_W-1:0]  mfirst;
  logic [fba_pkg::FRAME_W-1:0]  mlast;
  logic                         mark_set;
  fba_pkg::status_t             res_status;
  logic [fba_pkg::FRAME_W-1:0]  res_base;
  logic                         out_vld;
  fba_pkg::status_t             out_status;
  logic [fba_pkg::FRAME_W-1:0]  out_base;

  logic [fba_pkg::ADDR_W-1:0]   first_word, last_word;
  logic [fba_pkg::BIT_W-1:0]    lo, hi;
  logic                         last_addr;
  logic                         last_chunk;
  logic [fba_pkg::RUN_W-1:0]    full_run;
  logic                         full_hit;
  logic [fba_pkg::FRAME_W-1:0]  word_base;
  logic [fba_pkg::FRAME_W-1:0]  full_found;

  logic [fba_pkg::CHUNK_BITS-1:0] bits;
  logic [fba_pkg::RUN_W-1:0]      r;
  logic                           hit;
  logic [fba_pkg::CBIT_W-1:0]     hit_j;
  logic [fba_pkg::BIT_W-1:0]      hit_off;
  logic [fba_pkg::FRAME_W-1:0]    chunk_found;
  logic                           out_free;

  assign rsp.valid      = out_vld;
  assign rsp.status     = out_status;
  assign rsp.base_frame = out_base;
  assign out_free       = !out_vld || rsp.ready;
  assign clear_done     = state != fba_pkg::E_CLEAR;
  assign cmd_ready      = state == fba_pkg::E_IDLE;

  // Bitmap memory with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  // Word geometry
  assign last_addr  = addr == fba_pkg::ADDR_W'(fba_pkg::MAP_DEPTH - 1);
  assign last_chunk = chunk == fba_pkg::CHUNK_W'(fba_pkg::CHUNKS - 1);
  assign word_base  = fba_pkg::FRAME_W'(addr) << fba_pkg::BIT_W;
  assign first_word = fba_pkg::ADDR_W'(mfirst >> fba_pkg::BIT_W);
  assign last_word  = fba_pkg::ADDR_W'(mlast >> fba_pkg::BIT_W);

  // Range mask for the current word
  always_comb begin
    lo   = (addr == first_word) ? mfirst[fba_pkg::BIT_W-1:0] : '0;
    hi   = (addr == last_word) ? mlast[fba_pkg::BIT_W-1:0] : fba_pkg::BIT_W'(W - 1);
    mask = (fba_pkg::WORD_FULL << lo)
         & (fba_pkg::WORD_FULL >> (fba_pkg::BIT_W'(W - 1) - hi));
  end

  // Whole free word extends the current run
  assign full_run   = run + fba_pkg::RUN_W'(W);
  assign full_hit   = full_run >= fba_pkg::RUN_W'(need_n);
  assign full_found = word_base - fba_pkg::FRAME_W'(run);

  // Walk one chunk of a mixed word bit by bit
  always_comb begin
    bits  = wbuf[chunk*fba_pkg::CHUNK_BITS +: fba_pkg::CHUNK_BITS];
    r     = run;
    hit   = 1'b0;
    hit_j = '0;
    for (int j = 0; j < fba_pkg::CHUNK_BITS; j++) begin
      if (!hit) begin
        if (bits[j]) begin
          r = r + 1'b1;
          if (r == fba_pkg::RUN_W'(need_n)) begin
            hit   = 1'b1;
            hit_j = fba_pkg::CBIT_W'(j);
          end
        end else begin
          r = '0;
        end
      end
    end
    hit_off     = fba_pkg::BIT_W'(fba_pkg::CHUNK_BITS * int'(chunk) + int'(hit_j));
    chunk_found = word_base + fba_pkg::FRAME_W'(hit_off) + 1'b1
                - fba_pkg::FRAME_W'(need_n);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fba_pkg::E_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory write control
  always_comb begin
    state_next = state;
    we         = 1'b0;
    wdata      = '0;
    unique case (state)
      fba_pkg::E_CLEAR: begin
        we = 1'b1;
        if (last_addr) state_next = fba_pkg::E_IDLE;
      end
      fba_pkg::E_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            fba_pkg::OP_ALLOC:   state_next = fba_pkg::E_SCAN_RD;
            fba_pkg::OP_RESERVE: state_next = fba_pkg::E_MARK_RD;
            fba_pkg::OP_RELEASE: state_next = fba_pkg::E_MARK_RD;
            fba_pkg::OP_REJECT:  state_next = fba_pkg::E_RESP;
          endcase
        end
      end
      fba_pkg::E_SCAN_RD: state_next = fba_pkg::E_SCAN_EXAM;
      fba_pkg::E_SCAN_EXAM: begin
        priority if (rdata == '0) begin
          state_next = last_addr ? fba_pkg::E_RESP : fba_pkg::E_SCAN_RD;
        end else if (rdata == fba_pkg::WORD_FULL) begin
          if (full_hit) state_next = fba_pkg::E_MARK_RD;
          else          state_next = last_addr ? fba_pkg::E_RESP : fba_pkg::E_SCAN_RD;
        end else begin
          state_next = fba_pkg::E_SCAN_CHUNK;
        end
      end
      fba_pkg::E_SCAN_CHUNK: begin
        priority if (hit)        state_next = fba_pkg::E_MARK_RD;
        else if (!last_chunk)    state_next = fba_pkg::E_SCAN_CHUNK;
        else if (last_addr)      state_next = fba_pkg::E_RESP;
        else                     state_next = fba_pkg::E_SCAN_RD;
      end
      fba_pkg::E_MARK_RD: state_next = fba_pkg::E_MARK_WR;
      fba_pkg::E_MARK_WR: begin
        we    = 1'b1;
        wdata = mark_set ? (rdata | mask) : (rdata & ~mask);
        state_next = (addr == last_word) ? fba_pkg::E_RESP : fba_pkg::E_MARK_RD;
      end
      fba_pkg::E_RESP: begin
        if (out_free) state_next = fba_pkg::E_IDLE;
      end
      default: state_next = fba_pkg::E_CLEAR;
    endcase
  end

  // Address walker
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      case (state)
        fba_pkg::E_CLEAR: addr <= last_addr ? '0 : addr + 1'b1;
        fba_pkg::E_IDLE: begin
          if (cmd_valid) begin
            addr <= (cmd.op == fba_pkg::OP_ALLOC) ? '0
                  : fba_pkg::ADDR_W'(cmd.first >> fba_pkg::BIT_W);
          end
        end
        fba_pkg::E_SCAN_EXAM: begin
          if (rdata == fba_pkg::WORD_FULL && full_hit) begin
            addr <= fba_pkg::ADDR_W'(full_found >> fba_pkg::BIT_W);
          end else if (rdata == '0 || rdata == fba_pkg::WORD_FULL) begin
            addr <= addr + 1'b1;
          end
        end
        fba_pkg::E_SCAN_CHUNK: begin
          if (hit) begin
            addr <= fba_pkg::ADDR_W'(chunk_found >> fba_pkg::BIT_W);
          end else if (last_chunk) begin
            addr <= addr + 1'b1;
          end
        end
        fba_pkg::E_MARK_WR: addr <= addr + 1'b1;
        default: addr <= addr;
      endcase
    end
  end

  // Scan and mark datapath
  always_ff @(posedge clk) begin
    case (state)
      fba_pkg::E_IDLE: begin
        need_n     <= cmd.count;
        run        <= '0;
        mfirst     <= cmd.first;
        mlast      <= cmd.first + fba_pkg::FRAME_W'(cmd.count) - 1'b1;
        mark_set   <= cmd.op == fba_pkg::OP_RELEASE;
        res_status <= (cmd.op == fba_pkg::OP_REJECT) ? fba_pkg::ST_BAD_REQ
                                                      : fba_pkg::ST_DONE;
        res_base   <= '0;
      end
      fba_pkg::E_SCAN_EXAM: begin
        chunk <= '0;
        wbuf  <= rdata;
        if (rdata == '0) begin
          run <= '0;
        end else if (rdata == fba_pkg::WORD_FULL) begin
          if (full_hit) begin
            res_base <= full_found;
            mfirst   <= full_found;
            mlast    <= full_found + fba_pkg::FRAME_W'(need_n) - 1'b1;
          end else begin
            run <= full_run;
          end
        end
        if (last_addr && !(rdata == fba_pkg::WORD_FULL && full_hit)
            && (rdata == '0 || rdata == fba_pkg::WORD_FULL)) begin
          res_status <= fba_pkg::ST_NO_SPACE;
        end
      end
      fba_pkg::E_SCAN_CHUNK: begin
        run   <= r;
        chunk <= chunk + 1'b1;
        if (hit) begin
          res_base <= chunk_found;
          mfirst   <= chunk_found;
          mlast    <= chunk_found + fba_pkg::FRAME_W'(need_n) - 1'b1;
        end else if (last_chunk && last_addr) begin
          res_status <= fba_pkg::ST_NO_SPACE;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load the result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == fba_pkg::E_RESP && out_free) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fba_pkg::E_RESP && out_free) begin
      out_status <= res_status;
      out_base   <= res_base;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == fba_pkg::E_CLEAR |-> !(cmd_valid && cmd_ready))
    else $error("command taken during clearing pass");

  a_base_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (state == fba_pkg::E_RESP && res_status != fba_pkg::ST_DONE) |-> res_base == '0)
    else $error("nonzero base on failed request");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    state == fba_pkg::E_MARK_WR |-> (addr >= first_word && addr <= last_word))
    else $error("mark walk left its range");

  a_run_below_need: assert property (@(posedge clk) disable iff (rst)
    state == fba_pkg::E_SCAN_CHUNK |-> run < fba_pkg::RUN_W'(need_n))
    else $error("scan kept going past a complete run");

endmodule

// ===== rtl/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: one availability bit per physical frame.
// req channel: func (allocate, reserve, release), first_frame, count.
// rsp channel: status (done, no space, bad request) and base_frame, one
// transaction per request, in request order.
// After reset the map is cleared word by word, all MAP_DEPTH words
// (16384 at the default geometry); req.ready stays low until then
// and every frame starts unavailable.
// A front stage classifies each request (zero count, bad function, range
// past end) and parks it in a two-entry queue; the back end walks the map
// through a single memory port; each word is read, then examined or written.
// A rejected request goes straight to the response; reserve and release
// read and write each map word touched; allocate skips all-free and
// all-used words whole, walks mixed words chunk by chunk up to the run
// found, then reads and writes each word of the run to mark it. One
// request is worked on at a time; the queue keeps accepting meanwhile.
// If the receiver stalls, the result waits in the output register, the
// back end finishes its next request and holds it, and the front fills.
module frame_bitmap_allocator (
  input  logic      clk,
  input  logic      rst,
  fba_req_if.sink   req,
  fba_rsp_if.source rsp
);

  logic           f_valid, f_ready;
  fba_pkg::cmd_t  f_cmd;
  logic           q_valid, q_ready;
  fba_pkg::cmd_t  q_cmd;
  logic           clear_done;

  fba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (clear_done),
    .req        (req),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd)
  );

  fba_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  fba_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .clear_done (clear_done),
    .rsp        (rsp)
  );

endmodule

// ===== test/frame_map_checker.sv =====
module frame_map_checker (
  input  logic clk,
  input  logic rst,
  fba_req_if   req,
  fba_rsp_if   rsp,
  output int   errors,
  output int   pending,
  output int   n_done,
  output int   n_no_space,
  output int   n_bad
);

  typedef struct {
    fba_pkg::status_t            status;
    logic [fba_pkg::FRAME_W-1:0] base;
  } grant_t;

  // Shadow availability map, one bit per frame, 1 = available
  fba_pkg::map_word_t frame_map [fba_pkg::MAP_DEPTH];
  grant_t             pending_grants [$];

  function automatic bit is_free(int unsigned f);
    if (f / fba_pkg::MAP_WORD_BITS >= fba_pkg::MAP_DEPTH) return 1'b0;
    return frame_map[f / fba_pkg::MAP_WORD_BITS][f % fba_pkg::MAP_WORD_BITS];
  endfunction

  function automatic void mark_frames(int unsigned first, int unsigned n, bit avail);
    int unsigned f;
    for (int unsigned k = 0; k < n; k++) begin
      f = first + k;
      if (f / fba_pkg::MAP_WORD_BITS < fba_pkg::MAP_DEPTH)
        frame_map[f / fba_pkg::MAP_WORD_BITS][f % fba_pkg::MAP_WORD_BITS] = avail;
    end
  endfunction

  // First-fit search from frame 0; skip whole empty or full words
  function automatic bit first_fit(int unsigned n, output int unsigned base);
    int unsigned        run;
    int unsigned        i;
    fba_pkg::map_word_t word;
    run  = 0;
    i    = 0;
    base = 0;
    while (i < fba_pkg::FRAME_COUNT) begin
      word = frame_map[i / fba_pkg::MAP_WORD_BITS];
      if (i % fba_pkg::MAP_WORD_BITS == 0 && word == '0) begin
        run = 0;
        i += fba_pkg::MAP_WORD_BITS;
        continue;
      end
      if (i % fba_pkg::MAP_WORD_BITS == 0 && word == fba_pkg::WORD_FULL
          && i + fba_pkg::MAP_WORD_BITS <= fba_pkg::FRAME_COUNT) begin
        if (run + fba_pkg::MAP_WORD_BITS >= n) begin
          base = i - run;
          return 1'b1;
        end
        run += fba_pkg::MAP_WORD_BITS;
        i += fba_pkg::MAP_WORD_BITS;
        continue;
      end
      if (is_free(i)) begin
        run++;
        if (run == n) begin
          base = i + 1 - n;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
      i++;
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow map and return the grant it yields
  function automatic grant_t predict_grant(logic [fba_pkg::FUNC_W-1:0] fn,
                                           logic [fba_pkg::FRAME_W-1:0] first,
                                           logic [fba_pkg::COUNT_W-1:0] cnt);
    grant_t      g;
    int unsigned base;
    g.status = fba_pkg::ST_DONE;
    g.base   = '0;
    if (cnt == 0 || !(fn == fba_pkg::FN_ALLOC || fn == fba_pkg::FN_RESERVE
                      || fn == fba_pkg::FN_RELEASE)) begin
      g.status = fba_pkg::ST_BAD_REQ;
    end else if (fn == fba_pkg::FN_ALLOC) begin
      if (first_fit(cnt, base)) begin
        mark_frames(base, cnt, 1'b0);
        g.base = base[fba_pkg::FRAME_W-1:0];
      end else begin
        g.status = fba_pkg::ST_NO_SPACE;
      end
    end else if (int'(first) + int'(cnt) > fba_pkg::FRAME_COUNT) begin
      g.status = fba_pkg::ST_BAD_REQ;
    end else begin
      mark_frames(first, cnt, fn == fba_pkg::FN_RELEASE);
    end
    return g;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Clear on reset; predict on each request, compare on each response
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      for (int w = 0; w < fba_pkg::MAP_DEPTH; w++) frame_map[w] = '0;
      pending_grants.delete();
      errors     = 0;
      n_done     = 0;
      n_no_space = 0;
      n_bad      = 0;
    end else begin
      if (req.valid && req.ready) begin
        g = predict_grant(req.func, req.first_frame, req.count);
        case (g.status)
          fba_pkg::ST_DONE:     n_done++;
          fba_pkg::ST_NO_SPACE: n_no_space++;
          default:              n_bad++;
        endcase
        pending_grants.push_back(g);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_grants.size() == 0) begin
          report("unexpected response, status", rsp.status, -1);
        end else begin
          g = pending_grants.pop_front();
          if (rsp.status !== g.status) report("status", rsp.status, g.status);
          if (rsp.base_frame !== g.base) report("base_frame", rsp.base_frame, g.base);
        end
      end
    end
    pending <= pending_grants.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;

  localparam int  N_RANDOM    = 1800;
  localparam int  WINDOW      = 16384;
  localparam int  LAST_FRAME  = fba_pkg::FRAME_COUNT - 1;
  localparam longint CYCLE_LIMIT = 60000000;
  localparam logic [fba_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fba_req_if req ();
  fba_rsp_if rsp ();

  frame_bitmap_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  int errors, pending, n_done, n_no_space, n_bad;

  frame_map_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .errors     (errors),
    .pending    (pending),
    .n_done     (n_done),
    .n_no_space (n_no_space),
    .n_bad      (n_bad)
  );

  longint cycles = 0;
  bit     hold_rsp  = 1'b0;
  bit     no_gaps   = 1'b0;
  int     burst_left = 0;
  int     sent = 0;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Response side: rotating stall patterns, plus one long hold on request
  initial begin
    int phase;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        phase = int'((cycles / 700) % 4);
        case (phase)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= ($urandom % 4 != 0);
          2:       rsp.ready <= (cycles % 3 == 0);
          default: rsp.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Offer one request; bursts of back-to-back transactions separated by gaps unless no_gaps is set
  task automatic offer(logic [fba_pkg::FUNC_W-1:0] fn, int unsigned first, int unsigned cnt);
    if (burst_left == 0) begin
      if (!no_gaps) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    req.valid       <= 1'b1;
    req.func        <= fn;
    req.first_frame <= first[fba_pkg::FRAME_W-1:0];
    req.count       <= cnt[fba_pkg::COUNT_W-1:0];
    burst_left--;
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic drain();
    req.valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int          pick;
    int unsigned first, cnt;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.func        <= fba_pkg::FN_ALLOC;
    req.first_frame <= '0;
    req.count       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty map, rejects, map edges, word boundaries, field extremes
    offer(fba_pkg::FN_ALLOC, 0, 1);
    offer(fba_pkg::FN_ALLOC, 0, 0);
    offer(FN_UNUSED, 5, 7);
    offer(fba_pkg::FN_RELEASE, LAST_FRAME, 1);
    offer(fba_pkg::FN_RELEASE, LAST_FRAME, 2);
    offer(fba_pkg::FN_RELEASE, 0, 65535);
    offer(fba_pkg::FN_ALLOC, 12345, 65535);
    offer(fba_pkg::FN_ALLOC, 0, 1);
    offer(fba_pkg::FN_ALLOC, 0, 1);
    offer(fba_pkg::FN_RELEASE, fba_pkg::FRAME_COUNT - 70, 70);
    offer(fba_pkg::FN_ALLOC, 0, 70);
    offer(fba_pkg::FN_RELEASE, 100, 50);
    offer(fba_pkg::FN_RESERVE, 120, 10);
    offer(fba_pkg::FN_ALLOC, 0, 15);
    offer(fba_pkg::FN_ALLOC, 0, 25);
    offer(fba_pkg::FN_RESERVE, 0, 65535);
    offer(fba_pkg::FN_RELEASE, 'hAAAAA, 'h5555);
    offer(fba_pkg::FN_RESERVE, 'hAAAAA, 'h5555);
    offer(fba_pkg::FN_RELEASE, 'h55555, 'hAAAA);
    offer(fba_pkg::FN_RESERVE, 'h55555, 'hAAAA);
    offer(fba_pkg::FN_RESERVE, 0, 0);
    offer(fba_pkg::FN_RELEASE, 0, WINDOW);

    // Random: mostly traffic inside a low window that is refreshed often
    for (int i = 0; i < N_RANDOM; i++) begin
      no_gaps = ((i / 150) % 3 == 1);
      if (i == 900) hold_rsp = 1'b1;
      if (i == 1300) drain();
      if (i % 25 == 0) offer(fba_pkg::FN_RELEASE, 0, WINDOW);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 2000) : $urandom_range(1, 64);
        offer(fba_pkg::FN_ALLOC, $urandom, cnt);
      end else if (pick < 92) begin
        first = $urandom_range(0, WINDOW - 400);
        offer((pick < 72) ? fba_pkg::FN_RELEASE : fba_pkg::FN_RESERVE, first,
              $urandom_range(1, 300));
      end else if (pick < 95) begin
        // Touch frames anywhere in the map, then take them back
        first = $urandom_range(0, fba_pkg::FRAME_COUNT - 17);
        cnt   = $urandom_range(1, 16);
        offer(fba_pkg::FN_RELEASE, first, cnt);
        offer(fba_pkg::FN_RESERVE, first, cnt);
      end else if (pick < 97) begin
        offer(fba_pkg::FN_RELEASE, LAST_FRAME - $urandom_range(0, 10),
              $urandom_range(20, 65535));
      end else if (pick < 98) begin
        offer($urandom_range(0, 3), $urandom, 0);
      end else begin
        offer(FN_UNUSED, $urandom, $urandom_range(1, 65535));
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d requests: %0d done, %0d no space, %0d rejected.",
             sent, n_done, n_no_space, n_bad);
    $display("Included map edges, full scans, stalls, a long response hold and a drain.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
